// ===== design/leb_pkg.sv =====
// types and constants shared by the leb128 encoder modules
// no dependencies
package leb_pkg;

    // action codes of an input transaction
    localparam logic [1:0] ACT_UNSIGNED = 2'd0;
    localparam logic [1:0] ACT_SIGNED   = 2'd1;
    localparam logic [1:0] ACT_PADDED   = 2'd2;

    localparam logic [6:0] GROUP_MASK = 7'h7f;
    localparam logic [7:0] CONT_FLAG  = 8'h80;
    localparam int unsigned SIGN_POS  = 6;
    localparam int unsigned PAD_BYTES = 5;
    localparam int unsigned MAX_BYTES = 10;

    typedef enum logic [1:0] {
        ENC_UNSIGNED,
        ENC_SIGNED,
        ENC_PADDED
    } enc_mode_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [63:0] value_bits;
    } leb_in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
    } leb_out_t;

    // work descriptor passed from front to back
    typedef struct packed {
        enc_mode_t   mode;
        logic [63:0] value;
    } leb_job_t;

endpackage

// ===== design/leb_front.sv =====
// front end: accepts input transactions, classifies action, builds jobs
// depends on leb_pkg
module leb_front
    import leb_pkg::*;
(
    input  logic     in_valid,
    output logic     in_ready,
    input  leb_in_t  in_data,
    output logic     job_valid,
    input  logic     job_ready,
    output leb_job_t job
);

    logic known;

    always_comb
    begin
        known     = 1'b1;
        job.value = in_data.value_bits;
        job.mode  = ENC_UNSIGNED;
        case (in_data.action)
            ACT_UNSIGNED: job.mode = ENC_UNSIGNED;
            ACT_SIGNED:   job.mode = ENC_SIGNED;
            ACT_PADDED:
            begin
                job.mode  = ENC_PADDED;
                job.value = {32'd0, in_data.value_bits[31:0]};
            end
            default:      known = 1'b0;
        endcase
    end

    // undefined actions are accepted and dropped
    assign in_ready  = job_ready;
    assign job_valid = in_valid && known;

endmodule

// ===== design/leb_queue.sv =====
// two-entry job queue between front and back
// depends on leb_pkg
module leb_queue
    import leb_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push_valid,
    output logic     push_ready,
    input  leb_job_t push_job,
    output logic     pop_valid,
    input  logic     pop_ready,
    output leb_job_t pop_job
);

    leb_job_t   mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_job    = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== design/leb_back.sv =====
// back end: shifts a job out as leb128 bytes into an output register
// depends on leb_pkg
module leb_back
    import leb_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     job_valid,
    output logic     job_ready,
    input  leb_job_t job,
    output logic     out_valid,
    input  logic     out_ready,
    output leb_out_t out_data
);

    logic        busy_reg, busy_next;
    logic [63:0] x_reg, x_next;
    enc_mode_t   mode_reg, mode_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic        ovalid_reg, ovalid_next;
    leb_out_t    odata_reg, odata_next;

    logic        out_free, step, done, load;
    logic [6:0]  group;
    logic [63:0] rest;

    assign out_free = !ovalid_reg || out_ready;
    assign step     = busy_reg && out_free;

    always_comb
    begin
        group = x_reg[6:0] & GROUP_MASK;
        if (mode_reg == ENC_SIGNED)
        begin
            rest = {{7{x_reg[63]}}, x_reg[63:7]};
        end
        else
        begin
            rest = {7'd0, x_reg[63:7]};
        end
        case (mode_reg)
            ENC_SIGNED:
                done = ((rest == '0) && !group[SIGN_POS])
                    || ((rest == '1) && group[SIGN_POS])
                    || (cnt_reg == 4'(MAX_BYTES - 1));
            ENC_PADDED:
                done = (cnt_reg == 4'(PAD_BYTES - 1));
            default:
                done = (rest == '0) || (cnt_reg == 4'(MAX_BYTES - 1));
        endcase
    end

    assign load      = job_valid && (!busy_reg || (step && done));
    assign job_ready = !busy_reg || (step && done);

    always_comb
    begin
        busy_next   = busy_reg;
        x_next      = x_reg;
        mode_next   = mode_reg;
        cnt_next    = cnt_reg;
        ovalid_next = ovalid_reg && !out_ready;
        odata_next  = odata_reg;
        if (step)
        begin
            ovalid_next         = 1'b1;
            odata_next.out_byte = {1'b0, group} | (done ? 8'd0 : CONT_FLAG);
            odata_next.last     = done;
            x_next              = rest;
            cnt_next            = cnt_reg + 4'd1;
            if (done)
            begin
                busy_next = 1'b0;
            end
        end
        if (load)
        begin
            busy_next = 1'b1;
            x_next    = job.value;
            mode_next = job.mode;
            cnt_next  = 4'd0;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg     <= x_next;
        mode_reg  <= mode_next;
        cnt_reg   <= cnt_next;
        odata_reg <= odata_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            busy_reg   <= busy_next;
            ovalid_reg <= ovalid_next;
        end
    end

    assign out_valid = ovalid_reg;
    assign out_data  = odata_reg;

endmodule

// ===== design/leb128_encoder.sv =====
// top level of the leb128 encoder: front, job queue and byte shifter
// depends on leb_pkg, leb_front, leb_queue, leb_back
//
// leb128 encoder. each input transaction carries an action and a 64-bit
// pattern and produces one output transaction per encoded byte, lowest
// 7-bit group first, with bit 7 set while more bytes follow and last set on
// the final byte. action 0 is unsigned leb128 (zero gives the single byte
// 0x00), action 1 is signed leb128, action 2 encodes the low 32 bits as
// exactly five bytes, and action 3 is accepted and produces nothing.
// timing: an item has 1 to 10 bytes, and the block streams one byte per
// cycle when the output is not stalled; the first byte of an item passes
// the queue, the shifter register and the output register. the front
// classifies items and hands them through a two-entry queue, so input
// keeps being taken while the shifter works and the queue has room.
module leb128_encoder
    import leb_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  leb_in_t  in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output leb_out_t out_data
);

    // front to queue
    logic     f_valid, f_ready;
    leb_job_t f_job;
    // queue to back
    logic     q_valid, q_ready;
    leb_job_t q_job;

    // classify the action and build the job
    leb_front u_front (
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .job_valid (f_valid),
        .job_ready (f_ready),
        .job       (f_job)
    );

    // decouples input acceptance from byte emission
    leb_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_job   (f_job),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_job    (q_job)
    );

    // one byte per cycle into a registered output while it is not stalled
    leb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (q_valid),
        .job_ready (q_ready),
        .job       (q_job),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
